/* sv/int8_dot_product_bias_scale_core_macros.svh */
// Assertion helpers used by the top-level core RTL file.
`ifndef INT8_DOT_PRODUCT_BIAS_SCALE_CORE_MACROS_SVH
`define INT8_DOT_PRODUCT_BIAS_SCALE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on clk_i, held off while rst_ni is low.
`define I8DP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define I8DP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define I8DP_ASSERT(lbl, prop, msg)
`define I8DP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/i8dp_pkg.sv */
`timescale 1ns / 1ps
package i8dp_pkg;

  localparam int unsigned FieldLanes  = 4;
  localparam int unsigned GroupLanes  = 4;
  localparam int unsigned ActiveLanes = (GroupLanes > FieldLanes) ? FieldLanes : GroupLanes;

  localparam logic [7:0]  BiasFactor = 8'd127;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [30:0] InfMag     = 31'h7F80_0000;

  // operand pair handed from the int-to-float stage to the multiplier
  typedef struct packed {
    logic [31:0] a_bits;
    logic [31:0] scale;
  } i8dp_mul_op_t;

  // leading zero count, six halving steps
  function automatic logic [5:0] lzc64(input logic [63:0] x);
    logic [63:0] v;
    logic [5:0]  n;
    v = x;
    n = '0;
    if (v[63:32] == '0) begin n[5] = 1'b1; v = v << 32; end
    if (v[63:48] == '0) begin n[4] = 1'b1; v = v << 16; end
    if (v[63:56] == '0) begin n[3] = 1'b1; v = v << 8;  end
    if (v[63:60] == '0) begin n[2] = 1'b1; v = v << 4;  end
    if (v[63:62] == '0) begin n[1] = 1'b1; v = v << 2;  end
    if (v[63] == 1'b0)  begin n[0] = 1'b1; end
    return n;
  endfunction

endpackage

/* sv/i8dp_i2f.sv */
`timescale 1ns / 1ps
module i8dp_i2f import i8dp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [31:0]  sum_i,
  input  logic [31:0]  scale_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output i8dp_mul_op_t out_op_o
);

  logic        v2_q, sign2_q, zero2_q;
  logic [31:0] mag2_q, scale2_q, mag_d;
  logic [4:0]  lz2_q;
  logic [5:0]  lz_full;
  logic        rdy2, rdy3, v3_q;
  i8dp_mul_op_t op3_q, op3_d;

  logic [31:0] norm;
  logic [7:0]  exp_d;
  logic        rnd;

  assign mag_d   = sum_i[31] ? (32'd0 - sum_i) : sum_i;
  assign lz_full = lzc64({mag_d, 32'd0});

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      sign2_q  <= sum_i[31];
      zero2_q  <= (sum_i == '0);
      mag2_q   <= mag_d;
      lz2_q    <= lz_full[4:0];
      scale2_q <= scale_i;
    end
  end

  // normalize, round to nearest even, pack; a mantissa carry bumps the exponent
  always_comb begin
    norm  = mag2_q << lz2_q;
    exp_d = 8'd158 - {3'd0, lz2_q};
    rnd   = norm[7] && ((|norm[6:0]) || norm[8]);
    op3_d.scale  = scale2_q;
    op3_d.a_bits = zero2_q ? 32'd0 : ({sign2_q, exp_d, norm[30:8]} + {31'd0, rnd});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      op3_q <= op3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_op_o    = op3_q;

endmodule

/* sv/i8dp_fmul.sv */
`timescale 1ns / 1ps
module i8dp_fmul import i8dp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  i8dp_mul_op_t in_op_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [31:0]  result_o
);

  logic rdy4, rdy5, rdy6, rdy7;
  logic v4_q, v5_q, v6_q, v7_q;

  // stage 4: unpack, special cases, mantissa product
  logic [31:0] a, b;
  logic        a_zero, b_nan, b_inf, b_zero, sx, spec_d;
  logic [31:0] specv_d;
  logic [23:0] ma, mb;
  logic [7:0]  eb;

  logic        sx4_q, spec4_q;
  logic [31:0] specv4_q;
  logic [47:0] prod4_q;
  logic [8:0]  esum4_q;

  always_comb begin
    a      = in_op_i.a_bits;
    b      = in_op_i.scale;
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    b_inf  = (b[30:0] == InfMag);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    sx     = a[31] ^ b[31];
    ma     = {1'b1, a[22:0]};
    mb     = {b[30:23] != '0, b[22:0]};
    eb     = (b[30:23] == '0) ? 8'd1 : b[30:23];
    spec_d = b_nan || b_inf || a_zero || b_zero;
    if (b_nan) begin
      specv_d = b | QuietBit;
    end else if (b_inf && a_zero) begin
      specv_d = DefaultNan;
    end else if (b_inf) begin
      specv_d = {sx, InfMag};
    end else begin
      specv_d = {sx, 31'd0};
    end
  end

  assign rdy7       = !v7_q || out_ready_i;
  assign rdy6       = !v6_q || rdy7;
  assign rdy5       = !v5_q || rdy6;
  assign rdy4       = !v4_q || rdy5;
  assign in_ready_o = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      sx4_q    <= sx;
      spec4_q  <= spec_d;
      specv4_q <= specv_d;
      prod4_q  <= ma * mb;
      esum4_q  <= {1'b0, a[30:23]} + {1'b0, eb};
    end
  end

  // stage 5: leading zeros of the product
  logic        sx5_q, spec5_q;
  logic [31:0] specv5_q;
  logic [47:0] prod5_q;
  logic [8:0]  esum5_q;
  logic [5:0]  lz5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      sx5_q    <= sx4_q;
      spec5_q  <= spec4_q;
      specv5_q <= specv4_q;
      prod5_q  <= prod4_q;
      esum5_q  <= esum4_q;
      lz5_q    <= lzc64({prod4_q, 16'd0});
    end
  end

  // stage 6: normalize, biased exponent, overflow to infinity
  logic signed [10:0] e_d, e6_q;
  logic        sx6_q, spec6_q;
  logic [31:0] specv6_q;
  logic [47:0] n6_q;

  assign e_d = $signed({2'd0, esum5_q}) - 11'sd126 - $signed({5'd0, lz5_q});

  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      sx6_q    <= sx5_q;
      n6_q     <= prod5_q << lz5_q;
      e6_q     <= e_d;
      spec6_q  <= spec5_q || (e_d > 11'sd254);
      specv6_q <= spec5_q ? specv5_q : {sx5_q, InfMag};
    end
  end

  // stage 7: denormal shift, round to nearest even, pack
  logic signed [10:0] shs;
  logic [5:0]  sh;
  logic [95:0] shifted;
  logic [23:0] f;
  logic [7:0]  exp8;
  logic        rnd;
  logic [31:0] r_d, r7_q;

  always_comb begin
    shs     = 11'sd25 - e6_q;
    sh      = (e6_q > 11'sd0) ? 6'd24 : shs[5:0];
    shifted = {n6_q, 48'd0} >> sh;
    f       = shifted[71:48];
    exp8    = (e6_q > 11'sd0) ? e6_q[7:0] : 8'd0;
    rnd     = shifted[47] && ((|shifted[46:0]) || f[0]);
    r_d     = spec6_q ? specv6_q : ({sx6_q, exp8, f[22:0]} + {31'd0, rnd});
  end

  always_ff @(posedge clk_i) begin
    if (rdy7 && v6_q) begin
      r7_q <= r_d;
    end
  end

  assign out_valid_o = v7_q;
  assign result_o    = r7_q;

endmodule

/* sv/int8_dot_product_bias_scale_core.sv */
`timescale 1ns / 1ps
// int8 dot product with bias and float32 scale. Takes one beat per clock while in_ready_o
// is high: each beat carries four int8 weight/activation pairs whose products add into a
// 32-bit wrapping row accumulator in the cycle the beat is taken. A beat with last_group
// set also adds bias_weight * 127, clears the accumulator, and sends the row sum down a
// six-stage float pipeline (int-to-float in two stages, float multiply by row_scale in
// four). The row sum passes the stage-1 register, the two int-to-float stages and the
// four multiplier stages before out_valid_o rises. Every stage has its own valid bit, so
// input keeps flowing while a result waits for out_ready_i, until all seven stages hold
// row sums.
`include "int8_dot_product_bias_scale_core_macros.svh"
module int8_dot_product_bias_scale_core import i8dp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [7:0] weight_a_i,
  input  logic signed [7:0] weight_b_i,
  input  logic signed [7:0] weight_c_i,
  input  logic signed [7:0] weight_d_i,
  input  logic signed [7:0] act_a_i,
  input  logic signed [7:0] act_b_i,
  input  logic signed [7:0] act_c_i,
  input  logic signed [7:0] act_d_i,
  input  logic signed [7:0] bias_weight_i,
  input  logic [31:0]       row_scale_i,
  input  logic              last_group_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       result_value_o
);

  logic signed [7:0]  wt [FieldLanes];
  logic signed [7:0]  ac [FieldLanes];
  logic signed [15:0] lane_prod [FieldLanes];
  logic signed [15:0] bias_prod;
  logic [31:0] dot, acc_d, sum_d;
  logic [31:0] acc_q, sum1_q, scale1_q;
  logic        v1_q, rdy1, accept, cvt_ready;

  assign wt = '{weight_a_i, weight_b_i, weight_c_i, weight_d_i};
  assign ac = '{act_a_i, act_b_i, act_c_i, act_d_i};

  // lane products; lanes past the configured count drop out
  always_comb begin
    dot = '0;
    for (int i = 0; i < FieldLanes; i++) begin
      lane_prod[i] = wt[i] * ac[i];
      if (i < ActiveLanes) begin
        dot = dot + 32'(lane_prod[i]);
      end
    end
  end

  assign bias_prod = bias_weight_i * $signed(BiasFactor);
  assign acc_d     = acc_q + dot;
  assign sum_d     = acc_d + 32'($signed(bias_prod));

  assign rdy1       = !v1_q || cvt_ready;
  assign in_ready_o = rdy1;
  assign accept     = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (accept) acc_q <= last_group_i ? 32'd0 : acc_d;
      if (rdy1)   v1_q  <= accept && last_group_i;
    end
  end

  // row sum and scale held for the converter
  always_ff @(posedge clk_i) begin
    if (accept && last_group_i) begin
      sum1_q   <= sum_d;
      scale1_q <= row_scale_i;
    end
  end

  i8dp_mul_op_t mul_op;
  logic         mul_valid, mul_ready;

  i8dp_i2f u_i2f (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (cvt_ready),
    .sum_i       (sum1_q),
    .scale_i     (scale1_q),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_op_o    (mul_op)
  );

  i8dp_fmul u_fmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_op_i     (mul_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_value_o)
  );

  `I8DP_ASSERT(a_last_clears_acc, accept && last_group_i |=> acc_q == 32'd0, "acc not cleared")
  `I8DP_ASSERT(a_acc_holds, !accept |=> $stable(acc_q), "acc moved without a beat")
  `I8DP_ASSERT(a_stage1_holds, v1_q && !cvt_ready |=> v1_q && $stable(sum1_q), "row sum lost")
  `I8DP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !v1_q && !out_valid_o, "valid during reset")

endmodule

/* tb/int8_dot_product_bias_scale_core_test.sv */
`timescale 1ns / 1ps
module int8_dot_product_bias_scale_core_test import i8dp_pkg::*;;

  // Row-sum predictor: mirrors the row accumulator and the float path.
  class row_sum_board;
    bit [31:0] row_acc;
    bit [31:0] expected_q[$];
    int        errors;

    function new();
      row_acc = '0;
      errors  = 0;
    endfunction

    // Round value = mag * 2^pow2 to float32, nearest even, subnormals kept.
    function bit [31:0] round_pack(bit sgn, bit [63:0] mag, int pow2);
      int        msb;
      int        biased;
      int        shift;
      bit [63:0] m;
      bit [63:0] rem;
      bit [63:0] half;
      msb = 63;
      while (mag[msb] == 1'b0) msb--;
      biased = msb + pow2 + 127;
      shift  = (biased >= 1) ? msb - 23 : -149 - pow2;
      if (shift >= 50) begin
        m = '0;
      end else if (shift > 0) begin
        m    = mag >> shift;
        rem  = mag & ((64'd1 << shift) - 1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && m[0])) m++;
      end else begin
        m = mag << (-shift);
      end
      if (biased < 1) return {sgn, 31'(m)};  // subnormal, may round up to min normal
      if (m == (64'd1 << 24)) begin
        m = m >> 1;
        biased++;
      end
      if (biased >= 255) return {sgn, InfMag};
      return {sgn, 8'(biased), m[22:0]};
    endfunction

    function bit [31:0] int_to_float(bit [31:0] s);
      bit [31:0] mag;
      mag = s[31] ? (32'd0 - s) : s;
      if (mag == 0) return '0;
      return round_pack(s[31], {32'd0, mag}, 0);
    endfunction

    function bit [31:0] float_mul(bit [31:0] a, bit [31:0] b);
      bit        sgn;
      bit [63:0] ma;
      bit [63:0] mb;
      int        ea;
      int        eb;
      sgn = a[31] ^ b[31];
      if (b[30:23] == 8'hFF && b[22:0] != 0) return b | QuietBit;
      if (b[30:0] == InfMag) begin
        if (a[30:0] == 0) return DefaultNan;
        return {sgn, InfMag};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
      // a comes from the int conversion, so it is always normal
      ma = {40'd0, 1'b1, a[22:0]};
      ea = a[30:23];
      if (b[30:23] == 0) begin
        mb = {41'd0, b[22:0]};
        eb = 1;
      end else begin
        mb = {40'd0, 1'b1, b[22:0]};
        eb = b[30:23];
      end
      return round_pack(sgn, ma * mb, (ea - 150) + (eb - 150));
    endfunction

    function void note_input(logic signed [7:0] w[4], logic signed [7:0] x[4],
                             logic signed [7:0] bias, logic [31:0] scale, logic last);
      for (int i = 0; i < ActiveLanes; i++)
        row_acc += 32'(int'(w[i]) * int'(x[i]));
      if (last) begin
        row_acc += 32'(int'(bias) * 127);
        expected_q.push_back(float_mul(int_to_float(row_acc), scale));
        row_acc = '0;
      end
    endfunction

    function void check_result(logic [31:0] got);
      bit [31:0] exp_val;
      if (expected_q.size() == 0) begin
        $error("result_value: unexpected beat, actual %h", got);
        errors++;
        return;
      end
      exp_val = expected_q.pop_front();
      if (got !== exp_val) begin
        $error("result_value: expected %h actual %h", exp_val, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic signed [7:0] weight_a_i, weight_b_i, weight_c_i, weight_d_i;
  logic signed [7:0] act_a_i, act_b_i, act_c_i, act_d_i;
  logic signed [7:0] bias_weight_i;
  logic [31:0]       row_scale_i;
  logic              last_group_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [31:0]       result_value_o;

  row_sum_board sb = new();

  // Idle / stall odds in percent, changed per phase.
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  int8_dot_product_bias_scale_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .weight_a_i     (weight_a_i),
    .weight_b_i     (weight_b_i),
    .weight_c_i     (weight_c_i),
    .weight_d_i     (weight_d_i),
    .act_a_i        (act_a_i),
    .act_b_i        (act_b_i),
    .act_c_i        (act_c_i),
    .act_d_i        (act_d_i),
    .bias_weight_i  (bias_weight_i),
    .row_scale_i    (row_scale_i),
    .last_group_i   (last_group_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sink: ready toggles at the falling edge, result beats checked at the rising edge.
  initial out_ready_i = 1'b0;
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
  end
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(result_value_o);
  end

  // Drives one group beat and holds it until taken.
  task automatic send_group(logic signed [7:0] w[4], logic signed [7:0] x[4],
                            logic signed [7:0] bias, logic [31:0] scale, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    weight_a_i    <= w[0];
    weight_b_i    <= w[1];
    weight_c_i    <= w[2];
    weight_d_i    <= w[3];
    act_a_i       <= x[0];
    act_b_i       <= x[1];
    act_c_i       <= x[2];
    act_d_i       <= x[3];
    bias_weight_i <= bias;
    row_scale_i   <= scale;
    last_group_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w, x, bias, scale, last);
  endtask

  // Mostly in-range int8, now and then the -128 corner.
  function automatic logic signed [7:0] rand_int8();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return -8'sd128;
    if (pick < 10) return ($urandom_range(1)) ? 8'sd127 : -8'sd127;
    return 8'($urandom_range(254) - 127);
  endfunction

  // Scale mix: ordinary values near one, plus every float corner.
  function automatic logic [31:0] rand_scale();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(15))
      0:       return {r[31], 31'h7F80_0000};             // infinity
      1:       return {r[31], 8'hFF, r[22:1], 1'b1};      // NaN
      2:       return {r[31], 31'd0};                     // zero
      3:       return {r[31], 8'h00, r[22:0]};            // subnormal
      4:       return {r[31], 8'(8'd200 + r[4:0]), r[22:0]}; // overflow side
      5:       return {r[31], 8'(8'd80 + r[4:0]), r[22:0]};  // underflow side
      6, 7:    return r;
      default: return {r[31], 8'(8'd110 + r[4:0]), r[22:0]};
    endcase
  endfunction

  task automatic send_random(int n_items);
    logic signed [7:0] w[4];
    logic signed [7:0] x[4];
    for (int k = 0; k < n_items; k++) begin
      foreach (w[i]) w[i] = rand_int8();
      foreach (x[i]) x[i] = rand_int8();
      send_group(w, x, rand_int8(), rand_scale(), ($urandom_range(3) == 0));
    end
  endtask

  task automatic send_directed();
    logic signed [7:0] w[4];
    logic signed [7:0] x[4];
    // full-scale positive and negative products, long row
    w = '{8'sd127, 8'sd127, 8'sd127, 8'sd127};
    x = '{8'sd127, -8'sd127, 8'sd127, -8'sd127};
    send_group(w, x, 8'sd0, 32'h0, 1'b0);
    x = '{8'sd127, 8'sd127, 8'sd127, 8'sd127};
    send_group(w, x, 8'sd5, 32'h0, 1'b0);            // bias ignored here
    send_group(w, x, 8'sd127, 32'h3F80_0000, 1'b1);  // scale 1.0
    // -128 in every lane, both operands
    w = '{-8'sd128, -8'sd128, -8'sd128, -8'sd128};
    x = '{-8'sd128, -8'sd128, -8'sd128, -8'sd128};
    send_group(w, x, -8'sd128, 32'hBF80_0000, 1'b1);
    x = '{8'sd127, 8'sd127, 8'sd127, 8'sd127};
    send_group(w, x, -8'sd127, 32'h4000_0000, 1'b1);
    // zero sum: infinity scale gives the default NaN, zero scale gives zero
    w = '{8'sd0, 8'sd0, 8'sd0, 8'sd0};
    send_group(w, x, 8'sd0, 32'h7F80_0000, 1'b1);
    send_group(w, x, 8'sd0, 32'hFF80_0000, 1'b1);
    send_group(w, x, 8'sd0, 32'h0000_0000, 1'b1);
    send_group(w, x, 8'sd0, 32'h7FC0_1234, 1'b1);
    // nonzero sum against infinity, signaling NaN, zeros, subnormal, huge, tiny
    send_group(w, x, 8'sd3, 32'h7F80_0000, 1'b1);
    send_group(w, x, -8'sd3, 32'h7F80_0000, 1'b1);
    send_group(w, x, 8'sd3, 32'hFF80_0001, 1'b1);
    send_group(w, x, 8'sd3, 32'h7FBF_FFFF, 1'b1);
    send_group(w, x, -8'sd1, 32'h8000_0000, 1'b1);
    send_group(w, x, 8'sd1, 32'h0000_0001, 1'b1);
    send_group(w, x, -8'sd127, 32'h807F_FFFF, 1'b1);
    send_group(w, x, 8'sd127, 32'h7F7F_FFFF, 1'b1);
    send_group(w, x, 8'sd1, 32'h0080_0000, 1'b1);
    send_group(w, x, 8'sd1, 32'h0040_0001, 1'b1);
    // mixed lanes over a two-group row, with a bias and a scale near one third
    w = '{8'sd127, -8'sd127, 8'sd101, -8'sd3};
    x = '{8'sd99, 8'sd1, -8'sd77, 8'sd127};
    send_group(w, x, 8'sd0, 32'h3F80_0000, 1'b0);
    send_group(w, x, 8'sd85, 32'h3EAA_AAAB, 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    weight_a_i    = '0;
    weight_b_i    = '0;
    weight_c_i    = '0;
    weight_d_i    = '0;
    act_a_i       = '0;
    act_b_i       = '0;
    act_c_i       = '0;
    act_d_i       = '0;
    bias_weight_i = '0;
    row_scale_i   = '0;
    last_group_i  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    // phases: free flowing, slow source, slow sink, light jitter on both
    send_random(175);
    src_idle_pct = 72;
    send_random(175);
    src_idle_pct  = 0;
    snk_stall_pct = 72;
    send_random(175);
    src_idle_pct  = 10;
    snk_stall_pct = 10;
    send_random(175);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);  // pipeline is 7 deep; catch stray beats
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
